// File: hdl/sfmre_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the sum-filtered mixed-radix enumerator.
// Field widths, command codes and config register indexes; no dependencies.
package sfmre_pkg;

  // Command item fields
  localparam int CMD_W  = 2;
  localparam int LIST_W = 3;
  localparam int SLOT_W = 4;
  localparam int VAL_W  = 8;
  localparam int CNT_W  = 5;

  // Result item fields
  localparam int POS_W = 3;

  // Config registers
  localparam int TGT_W      = 11;
  localparam int NPOS_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int VAL_MAX = (1 << VAL_W) - 1;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REWIND = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SUM = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITIONS  = 4'd1;

endpackage

// File: hdl/sfmre_cfg_if.sv
`timescale 1ns / 1ps
// Config write channel: valid/ready, register index and write data.
// Depends on sfmre_pkg for widths.
interface sfmre_cfg_if import sfmre_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: hdl/sfmre_cmd_if.sv
`timescale 1ns / 1ps
// Command channel: valid/ready plus one command item.
// Depends on sfmre_pkg for widths.
interface sfmre_cmd_if import sfmre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [LIST_W-1:0] list_index;
  logic [SLOT_W-1:0] entry_index;
  logic [VAL_W-1:0]  entry_value;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, output command, output list_index, output entry_index,
                  output entry_value, output entry_count, input ready);
  modport sink   (input valid, input command, input list_index, input entry_index,
                  input entry_value, input entry_count, output ready);
endinterface

// File: hdl/sfmre_res_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready plus one result item.
// Depends on sfmre_pkg for widths.
interface sfmre_res_if import sfmre_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] element;
  logic             last;

  modport source (output valid, output found, output position, output element,
                  output last, input ready);
  modport sink   (input valid, input found, input position, input element,
                  input last, output ready);
endinterface

// File: hdl/sum_filtered_mixed_radix_enumerator_core.sv
`timescale 1ns / 1ps
// Top level of the sum-filtered mixed-radix enumerator.
// Uses sfmre_pkg, the three channel interfaces and sfmre_ram (value table).
//
// Usage
//   cfg_i : register writes (target sum, positions in use), always ready.
//   cmd_i : one command per transaction: load entry, set list count, rewind,
//           next match. Ready only while the sequencer is idle.
//   res_o : result transactions. A match gives one transaction per position,
//           last set on the final one; exhaustion gives a single transaction
//           with found low.
// Sequence
//   Load, count and rewind give no result.
//   Next match: a read and a cache step per position to load the current digit
//   values out of the table, the start-combination check, then a step and an
//   update state per digit change while the odometer steps one combination at
//   a time, then one result per position. The step loop (one table read per
//   digit change) dominates, so the total depends on how far the next match lies.
//   Next match while exhausted: the sequencer moves to its exhaustion emit
//   state, which registers the one result once the output register is free.
// Reset clears the odometer, list counts read as full, the config registers
// return to target 0 and one position. The value table is not cleared.
// A stalled receiver holds the output register; the sequencer waits in its
// emit state, and once it is back to idle new commands are taken even while
// the final result still sits in the output register.
module sum_filtered_mixed_radix_enumerator_core import sfmre_pkg::*; #(
  parameter int MAX_POSITIONS = 8,
  parameter int MAX_ENTRIES   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfmre_cfg_if.sink  cfg_i,
  sfmre_cmd_if.sink  cmd_i,
  sfmre_res_if.source res_o
);

  localparam int PW      = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int DW      = $clog2(MAX_ENTRIES);
  localparam int AW      = PW + DW;
  localparam int SUM_MAX = MAX_POSITIONS * VAL_MAX;
  localparam int SUMW    = $clog2(SUM_MAX + 1);
  localparam int CMPW    = (SUMW > TGT_W) ? SUMW : TGT_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PRIME_RD = 3'd1;  // read value under current digit
  localparam logic [2:0] ST_PRIME_WR = 3'd2;  // cache it and add into sum
  localparam logic [2:0] ST_CHECK    = 3'd3;  // start combination after rewind
  localparam logic [2:0] ST_STEP     = 3'd4;  // advance digit at ptr, issue read
  localparam logic [2:0] ST_UPD      = 3'd5;  // fold new value into sum
  localparam logic [2:0] ST_EMIT     = 3'd6;
  localparam logic [2:0] ST_EMIT_EX  = 3'd7;

  // Config registers
  logic [TGT_W-1:0]  target_q;
  logic [NPOS_W-1:0] npos_q;

  // Per-position state, always indexed by ptr_q on the read side
  logic [DW-1:0]    digit_q [MAX_POSITIONS];
  logic [VAL_W-1:0] vals_q  [MAX_POSITIONS];
  logic [CNT_W-1:0] count_q [MAX_POSITIONS];

  logic [2:0]      state_q, state_d;
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [SUMW-1:0] sum_q, sum_d;
  logic            fresh_q, fresh_d;
  logic            exhausted_q, exhausted_d;
  logic [DW-1:0]   new_digit_q, new_digit_d;
  logic            carry_q, carry_d;

  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  logic [POS_W-1:0] out_pos_q, out_pos_d;
  logic [VAL_W-1:0] out_elem_q, out_elem_d;
  logic             out_last_q, out_last_d;

  logic            cmd_acc, res_free;
  logic            list_ok, slot_ok;
  logic [PW-1:0]   list_sel;
  logic [DW-1:0]   slot_sel;
  logic [PW-1:0]   n_last;
  logic [CNT_W-1:0] cnt_cur;
  logic [DW-1:0]   cur_digit, last_digit, step_digit;
  logic            at_last;
  logic [SUMW-1:0] sum_upd;
  logic            hit_cur, hit_upd;
  logic            digit_we, digits_clear, vals_we, count_we;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  // ---------------------------------------------------------------------
  // Config port
  // ---------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      npos_q   <= NPOS_W'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_TARGET_SUM: target_q <= cfg_i.wdata[TGT_W-1:0];
        REG_POSITIONS:  npos_q   <= cfg_i.wdata[NPOS_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Decode and derived limits
  // ---------------------------------------------------------------------
  assign cmd_acc  = cmd_i.valid && cmd_i.ready;
  assign res_free = !out_valid_q || res_o.ready;

  // Loads and counts beyond the table are dropped
  assign list_ok  = (32'(cmd_i.list_index) < MAX_POSITIONS);
  assign slot_ok  = (32'(cmd_i.entry_index) < MAX_ENTRIES);
  assign list_sel = PW'(cmd_i.list_index);
  assign slot_sel = DW'(cmd_i.entry_index);

  // Highest position in use: zero acts as one, overrange clamps
  always_comb begin
    if (npos_q == '0) begin
      n_last = '0;
    end else if (32'(npos_q) > MAX_POSITIONS) begin
      n_last = PW'(MAX_POSITIONS - 1);
    end else begin
      n_last = PW'(npos_q - NPOS_W'(1));
    end
  end

  // Last valid digit of the list at ptr: count zero acts as one, overrange clamps
  assign cnt_cur = count_q[ptr_q];
  always_comb begin
    if (cnt_cur == '0) begin
      last_digit = '0;
    end else if (32'(cnt_cur) > MAX_ENTRIES) begin
      last_digit = DW'(MAX_ENTRIES - 1);
    end else begin
      last_digit = DW'(cnt_cur - CNT_W'(1));
    end
  end

  // A digit at or past its last entry carries
  assign cur_digit  = digit_q[ptr_q];
  assign at_last    = (cur_digit >= last_digit);
  assign step_digit = at_last ? '0 : cur_digit + DW'(1);

  // Swap the old value at ptr for the one just read
  assign sum_upd = sum_q - SUMW'(vals_q[ptr_q]) + SUMW'(ram_rdata);
  assign hit_cur = (CMPW'(sum_q) == CMPW'(target_q));
  assign hit_upd = (CMPW'(sum_upd) == CMPW'(target_q));

  // ---------------------------------------------------------------------
  // Value table
  // ---------------------------------------------------------------------
  assign ram_we    = cmd_acc && (cmd_i.command == CMD_LOAD) && list_ok && slot_ok;
  assign ram_waddr = {list_sel, slot_sel};
  assign ram_raddr = {ptr_q, (state_q == ST_STEP) ? step_digit : cur_digit};

  sfmre_ram #(
    .WIDTH (VAL_W),
    .DEPTH (1 << AW)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.entry_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign cmd_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    sum_d        = sum_q;
    fresh_d      = fresh_q;
    exhausted_d  = exhausted_q;
    new_digit_d  = new_digit_q;
    carry_d      = carry_q;
    digit_we     = 1'b0;
    digits_clear = 1'b0;
    vals_we      = 1'b0;
    count_we     = 1'b0;

    out_valid_d = out_valid_q && !res_o.ready;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    out_elem_d  = out_elem_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_acc) begin
          case (cmd_i.command)
            CMD_LOAD: ;  // table write handled at the RAM port
            CMD_COUNT: count_we = list_ok;
            CMD_REWIND: begin
              digits_clear = 1'b1;
              fresh_d      = 1'b1;
              exhausted_d  = 1'b0;
            end
            CMD_NEXT: begin
              if (exhausted_q) begin
                state_d = ST_EMIT_EX;
              end else begin
                ptr_d   = '0;
                sum_d   = '0;
                state_d = ST_PRIME_RD;
              end
            end
            default: ;
          endcase
        end
      end

      ST_PRIME_RD: state_d = ST_PRIME_WR;

      ST_PRIME_WR: begin
        vals_we = 1'b1;
        sum_d   = sum_q + SUMW'(ram_rdata);
        if (ptr_q == n_last) begin
          ptr_d   = '0;
          state_d = ST_CHECK;
        end else begin
          ptr_d   = ptr_q + PW'(1);
          state_d = ST_PRIME_RD;
        end
      end

      ST_CHECK: begin
        // the start combination counts only on the first search after rewind
        if (fresh_q) begin
          fresh_d = 1'b0;
          state_d = hit_cur ? ST_EMIT : ST_STEP;
        end else begin
          state_d = ST_STEP;
        end
      end

      ST_STEP: begin
        new_digit_d = step_digit;
        carry_d     = at_last;
        state_d     = ST_UPD;
      end

      ST_UPD: begin
        digit_we = 1'b1;
        vals_we  = 1'b1;
        sum_d    = sum_upd;
        if (carry_q) begin
          if (ptr_q == n_last) begin
            // carry out of the top digit: every combination visited
            exhausted_d = 1'b1;
            state_d     = ST_EMIT_EX;
          end else begin
            ptr_d   = ptr_q + PW'(1);
            state_d = ST_STEP;
          end
        end else begin
          ptr_d   = '0;
          state_d = hit_upd ? ST_EMIT : ST_STEP;
        end
      end

      ST_EMIT: begin
        if (res_free) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b1;
          out_pos_d   = POS_W'(ptr_q);
          out_elem_d  = vals_q[ptr_q];
          out_last_d  = (ptr_q == n_last);
          if (ptr_q == n_last) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d = ptr_q + PW'(1);
          end
        end
      end

      ST_EMIT_EX: begin
        if (res_free) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b0;
          out_pos_d   = '0;
          out_elem_d  = '0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      sum_q       <= '0;
      fresh_q     <= 1'b1;
      exhausted_q <= 1'b0;
      new_digit_q <= '0;
      carry_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      sum_q       <= sum_d;
      fresh_q     <= fresh_d;
      exhausted_q <= exhausted_d;
      new_digit_q <= new_digit_d;
      carry_q     <= carry_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
    out_elem_q  <= out_elem_d;
    out_last_q  <= out_last_d;
  end

  // Odometer digits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_POSITIONS; i++) begin
        digit_q[i] <= '0;
      end
    end else if (digits_clear) begin
      for (int i = 0; i < MAX_POSITIONS; i++) begin
        digit_q[i] <= '0;
      end
    end else if (digit_we) begin
      digit_q[ptr_q] <= new_digit_q;
    end
  end

  // List counts, reset to all ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_POSITIONS; i++) begin
        count_q[i] <= '1;
      end
    end else if (count_we) begin
      count_q[list_sel] <= cmd_i.entry_count;
    end
  end

  // Cached values under the current digits
  always_ff @(posedge clk_i) begin
    if (vals_we) begin
      vals_q[ptr_q] <= ram_rdata;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.found    = out_found_q;
  assign res_o.position = out_pos_q;
  assign res_o.element  = out_elem_q;
  assign res_o.last     = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_exhaust_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> out_last_q && (out_elem_q == '0) && (out_pos_q == '0))
    else $error("exhaustion result with bad payload");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sum_q) <= SUM_MAX)
    else $error("running sum out of range");

  a_exhaust_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(exhausted_q) |-> ($past(state_q) == ST_UPD) && $past(carry_q))
    else $error("exhausted set outside a top-digit carry");

  a_emit_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) || (state_q == ST_UPD) |-> ptr_q <= n_last)
    else $error("position pointer past last position in use");

  a_next_exh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && (cmd_i.command == CMD_NEXT) && exhausted_q |=> state_q == ST_EMIT_EX)
    else $error("next while exhausted did not go to exhaustion result");

endmodule

// File: hdl/sfmre_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sfmre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
